[rtl/utf8_to_ascii_transliterator_defines.svh]
// assertion macros for the utf-8 to ascii transliterator
`ifndef UTF8_TO_ASCII_TRANSLITERATOR_DEFINES_SVH
`define UTF8_TO_ASCII_TRANSLITERATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define UTA_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define UTA_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define UTA_ASSERT_IMP(name, ante, cons, msg)

`define UTA_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

[rtl/uta_pkg.sv]
// shared types, constants and character tables of the transliterator
`default_nettype none

package uta_pkg;

   localparam int COUNT_BITS = 16;
   localparam int CAP_BITS   = 16;
   localparam int CMP_BITS   = ((COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS) + 2;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   localparam int RUN_MAX  = 4;
   localparam int ADDR_BITS = 3;
   localparam int DATA_BITS = 32;

   localparam logic [CAP_BITS-1:0] CAPACITY_RESET = CAP_BITS'(256);

   // register index, taken from byte address bit 2
   typedef enum logic {
      REG_CAPACITY = 1'b0,
      REG_KEEP_NL  = 1'b1
   } reg_idx_type;

   localparam logic [6:0] CH_NUL   = 7'h00;
   localparam logic [6:0] CH_TAB   = 7'h09;
   localparam logic [6:0] CH_LF    = 7'h0A;
   localparam logic [6:0] CH_CR    = 7'h0D;
   localparam logic [6:0] CH_SPACE = 7'h20;
   localparam logic [6:0] CH_QMARK = 7'h3F;

   typedef struct packed {
      logic [CAP_BITS-1:0] capacity;
      logic                keep_newlines;
   } cfg_type;

   // up to four characters, slot 0 first
   typedef struct packed {
      logic [2:0]                len;
      logic [RUN_MAX-1:0][6:0]   chr;
   } text_type;

   // results caused by one input byte
   typedef struct packed {
      logic [2:0]                cnt;
      logic                      term;
      logic [RUN_MAX-1:0][6:0]   chr;
   } run_type;

   function automatic text_type mk_text(input logic [2:0] len, input logic [6:0] c0,
                                        input logic [6:0] c1, input logic [6:0] c2,
                                        input logic [6:0] c3);
      text_type t;
      t.len    = len;
      t.chr[0] = c0;
      t.chr[1] = c1;
      t.chr[2] = c2;
      t.chr[3] = c3;
      return t;
   endfunction

   // substitution for a code point at or above 0x80
   function automatic text_type translit(input logic [20:0] cp);
      text_type t;
      unique case (cp)
         21'h2013: t = mk_text(3'd1, 7'h2D, CH_NUL, CH_NUL, CH_NUL);
         21'h2014: t = mk_text(3'd2, 7'h2D, 7'h2D, CH_NUL, CH_NUL);
         21'h2018, 21'h2019, 21'h201A, 21'h201B:
            t = mk_text(3'd1, 7'h27, CH_NUL, CH_NUL, CH_NUL);
         21'h201C, 21'h201D, 21'h201E, 21'h201F:
            t = mk_text(3'd1, 7'h22, CH_NUL, CH_NUL, CH_NUL);
         21'h2026: t = mk_text(3'd3, 7'h2E, 7'h2E, 7'h2E, CH_NUL);
         21'h2022, 21'h00B7, 21'h2219:
            t = mk_text(3'd1, 7'h2A, CH_NUL, CH_NUL, CH_NUL);
         21'h2190: t = mk_text(3'd2, 7'h3C, 7'h2D, CH_NUL, CH_NUL);
         21'h2192: t = mk_text(3'd2, 7'h2D, 7'h3E, CH_NUL, CH_NUL);
         21'h2191: t = mk_text(3'd1, 7'h5E, CH_NUL, CH_NUL, CH_NUL);
         21'h2193, 21'h2713, 21'h2714:
            t = mk_text(3'd1, 7'h76, CH_NUL, CH_NUL, CH_NUL);
         21'h00A0: t = mk_text(3'd1, CH_SPACE, CH_NUL, CH_NUL, CH_NUL);
         21'h00AB: t = mk_text(3'd2, 7'h3C, 7'h3C, CH_NUL, CH_NUL);
         21'h00BB: t = mk_text(3'd2, 7'h3E, 7'h3E, CH_NUL, CH_NUL);
         21'h2717, 21'h2718, 21'h2715, 21'h00D7:
            t = mk_text(3'd1, 7'h78, CH_NUL, CH_NUL, CH_NUL);
         21'h00A9: t = mk_text(3'd3, 7'h28, 7'h63, 7'h29, CH_NUL);
         21'h00AE: t = mk_text(3'd3, 7'h28, 7'h52, 7'h29, CH_NUL);
         21'h2122: t = mk_text(3'd4, 7'h28, 7'h54, 7'h4D, 7'h29);
         21'h00B0: t = mk_text(3'd3, 7'h64, 7'h65, 7'h67, CH_NUL);
         21'h00B1: t = mk_text(3'd3, 7'h2B, 7'h2F, 7'h2D, CH_NUL);
         21'h00F7: t = mk_text(3'd1, 7'h2F, CH_NUL, CH_NUL, CH_NUL);
         default:  t = mk_text(3'd1, CH_QMARK, CH_NUL, CH_NUL, CH_NUL);
      endcase
      return t;
   endfunction

   // text for a fully decoded code point
   function automatic text_type code_text(input logic [20:0] cp, input logic keep_nl);
      text_type t;
      logic [6:0] c;
      c = cp[6:0];
      if (cp >= 21'h80) begin
         t = translit(cp);
      end else if ((c == CH_LF || c == CH_CR) && keep_nl) begin
         t = mk_text(3'd1, c, CH_NUL, CH_NUL, CH_NUL);
      end else if (c == CH_LF || c == CH_CR || c == CH_TAB) begin
         t = mk_text(3'd1, CH_SPACE, CH_NUL, CH_NUL, CH_NUL);
      end else if (c < CH_SPACE) begin
         t = mk_text(3'd0, CH_NUL, CH_NUL, CH_NUL, CH_NUL);
      end else begin
         t = mk_text(3'd1, c, CH_NUL, CH_NUL, CH_NUL);
      end
      return t;
   endfunction

endpackage

`default_nettype wire

[rtl/uta_csr.sv]
// configuration registers behind the apb-style port
`default_nettype none

module uta_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [uta_pkg::ADDR_BITS-1:0]    csr_paddr,
   input  wire logic [uta_pkg::DATA_BITS-1:0]    csr_pwdata,
   output logic      [uta_pkg::DATA_BITS-1:0]    csr_prdata,
   output logic                                  csr_pready,
   output uta_pkg::cfg_type                      cfg
);
   import uta_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type reg_idx;
   logic        wr_en;

   assign reg_idx = reg_idx_type'(csr_paddr[2]);
   assign wr_en   = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_CAPACITY: cfg_in.capacity      = csr_pwdata[CAP_BITS-1:0];
            REG_KEEP_NL:  cfg_in.keep_newlines = csr_pwdata[0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.capacity      <= CAPACITY_RESET;
         cfg_ff.keep_newlines <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_CAPACITY: csr_prdata = DATA_BITS'(cfg_ff.capacity);
         REG_KEEP_NL:  csr_prdata = DATA_BITS'(cfg_ff.keep_newlines);
         default:      csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

`default_nettype wire

[rtl/uta_decode.sv]
// utf-8 sequence decoder, substitution and output-count limiting
`default_nettype none

module uta_decode (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic [7:0]       in_byte,
   input  wire uta_pkg::cfg_type cfg,
   output uta_pkg::run_type      run
);
   import uta_pkg::*;

   logic [20:0]           code_accum_ff, code_accum_in;
   logic [1:0]            bytes_pending_ff, bytes_pending_in;
   logic [COUNT_BITS-1:0] out_count_ff, out_count_in;

   text_type              lead_text;
   logic [20:0]           lead_accum;
   logic [1:0]            lead_pending;
   logic [20:0]           cont_accum;
   logic [1:0]            cont_pending;
   text_type              body;
   text_type              text;
   logic                  prefix;
   logic                  term;
   logic [RUN_MAX-1:0]    room;
   logic [2:0]            take;

   // lead byte handling
   always_comb begin
      lead_text    = mk_text(3'd0, CH_NUL, CH_NUL, CH_NUL, CH_NUL);
      lead_accum   = '0;
      lead_pending = 2'd0;
      if (!in_byte[7]) begin
         lead_text = code_text({13'b0, in_byte}, cfg.keep_newlines);
      end else if (in_byte[7:5] == 3'b110) begin
         lead_accum   = {16'b0, in_byte[4:0]};
         lead_pending = 2'd1;
      end else if (in_byte[7:4] == 4'b1110) begin
         lead_accum   = {17'b0, in_byte[3:0]};
         lead_pending = 2'd2;
      end else if (in_byte[7:3] == 5'b11110) begin
         lead_accum   = {18'b0, in_byte[2:0]};
         lead_pending = 2'd3;
      end else begin
         lead_text = mk_text(3'd1, CH_QMARK, CH_NUL, CH_NUL, CH_NUL);
      end
   end

   assign cont_accum   = {code_accum_ff[14:0], in_byte[5:0]};
   assign cont_pending = bytes_pending_ff - 2'd1;

   always_comb begin
      body             = mk_text(3'd0, CH_NUL, CH_NUL, CH_NUL, CH_NUL);
      prefix           = 1'b0;
      term             = 1'b0;
      code_accum_in    = code_accum_ff;
      bytes_pending_in = bytes_pending_ff;
      priority if (in_byte == 8'h00) begin
         // zero byte inside a sequence still gets its question mark
         prefix           = (bytes_pending_ff != 2'd0);
         term             = (cfg.capacity != '0);
         code_accum_in    = '0;
         bytes_pending_in = 2'd0;
      end else if (bytes_pending_ff != 2'd0 && in_byte[7:6] == 2'b10) begin
         bytes_pending_in = cont_pending;
         if (cont_pending == 2'd0) begin
            body          = code_text(cont_accum, cfg.keep_newlines);
            code_accum_in = '0;
         end else begin
            code_accum_in = cont_accum;
         end
      end else if (bytes_pending_ff != 2'd0) begin
         // broken sequence: question mark, then the byte starts over as a lead
         prefix           = 1'b1;
         body             = lead_text;
         code_accum_in    = lead_accum;
         bytes_pending_in = lead_pending;
      end else begin
         body             = lead_text;
         code_accum_in    = lead_accum;
         bytes_pending_in = lead_pending;
      end
   end

   always_comb begin
      if (prefix) begin
         text.len    = body.len + 3'd1;
         text.chr[0] = CH_QMARK;
         text.chr[1] = body.chr[0];
         text.chr[2] = body.chr[1];
         text.chr[3] = body.chr[2];
      end else begin
         text = body;
      end
   end

   // how many characters still fit in the buffer
   always_comb begin
      take = 3'd0;
      for (int i = 0; i < RUN_MAX; i++) begin
         room[i] = (CMP_BITS'(out_count_ff) + CMP_BITS'(i) + CMP_BITS'(1)
                       < CMP_BITS'(cfg.capacity))
                   && (CMP_BITS'(out_count_ff) + CMP_BITS'(i) < CMP_BITS'(COUNT_MAX));
         if (room[i] && (3'(i) < text.len)) begin
            take = 3'(i + 1);
         end
      end
   end

   always_comb begin
      run.cnt  = take + {2'b0, term};
      run.term = term;
      for (int j = 0; j < RUN_MAX; j++) begin
         run.chr[j] = (3'(j) < take) ? text.chr[j] : CH_NUL;
      end
   end

   assign out_count_in = (in_byte == 8'h00) ? '0
                                            : out_count_ff + COUNT_BITS'(take);

   always_ff @(posedge clock) begin
      if (reset) begin
         code_accum_ff    <= '0;
         bytes_pending_ff <= 2'd0;
         out_count_ff     <= '0;
      end else if (accept) begin
         code_accum_ff    <= code_accum_in;
         bytes_pending_ff <= bytes_pending_in;
         out_count_ff     <= out_count_in;
      end
   end

endmodule

`default_nettype wire

[rtl/uta_out.sv]
// result register that hands out one character of a run per cycle while rsp_ready is high
`default_nettype none

module uta_out (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             load,
   input  wire uta_pkg::run_type run,
   output logic                  load_ok,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [6:0]            rsp_out_char,
   output logic                  rsp_string_end,
   output logic                  rsp_run_last
);
   import uta_pkg::*;

   logic [RUN_MAX-1:0][6:0] chr_ff, chr_in;
   logic [2:0]              rem_ff, rem_in;
   logic                    term_ff, term_in;
   logic                    take;
   logic                    last;

   assign last      = (rem_ff == 3'd1);
   assign rsp_valid = (rem_ff != 3'd0);
   assign take      = rsp_valid && rsp_ready;
   // a new run may enter as the last character of the current one leaves
   assign load_ok   = !rsp_valid || (last && rsp_ready);

   always_comb begin
      chr_in  = chr_ff;
      rem_in  = rem_ff;
      term_in = term_ff;
      priority if (load) begin
         chr_in  = run.chr;
         rem_in  = run.cnt;
         term_in = run.term;
      end else if (take) begin
         chr_in = {CH_NUL, chr_ff[RUN_MAX-1:1]};
         rem_in = rem_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 3'd0;
      end else begin
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      chr_ff  <= chr_in;
      term_ff <= term_in;
   end

   assign rsp_out_char   = chr_ff[0];
   assign rsp_run_last   = last;
   assign rsp_string_end = last && term_ff;

endmodule

`default_nettype wire

[rtl/utf8_to_ascii_transliterator.sv]
// output: an item's first result is offered in the cycle after the item is taken
// throughput: one item per cycle while each item gives at most one result and
//   rsp_ready is high; an item giving n results (up to 4) holds the output register
//   until its last result is taken, the single result register sets that rate
// reset: synchronous, active high; clears the decoder, the output count and the
//   result register, capacity returns to 256 and keep-newlines to 0
`default_nettype none

`include "utf8_to_ascii_transliterator_defines.svh"

module utf8_to_ascii_transliterator (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [7:0]                       req_in_byte,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [6:0]                            rsp_out_char,
   output logic                                  rsp_string_end,
   output logic                                  rsp_run_last,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [uta_pkg::ADDR_BITS-1:0]    csr_paddr,
   input  wire logic [uta_pkg::DATA_BITS-1:0]    csr_pwdata,
   output logic      [uta_pkg::DATA_BITS-1:0]    csr_prdata,
   output logic                                  csr_pready
);
   import uta_pkg::*;

   cfg_type cfg;
   run_type run;
   logic    accept;
   logic    load_ok;

   assign req_ready = load_ok;
   assign accept    = req_valid && req_ready;

   uta_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   uta_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_in_byte),
      .cfg     (cfg),
      .run     (run)
   );

   uta_out u_out (
      .clock          (clock),
      .reset          (reset),
      .load           (accept),
      .run            (run),
      .load_ok        (load_ok),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_char   (rsp_out_char),
      .rsp_string_end (rsp_string_end),
      .rsp_run_last   (rsp_run_last)
   );

   `UTA_ASSERT_IMP(a_end_is_last, rsp_valid && rsp_string_end, rsp_run_last, "end not last")
   `UTA_ASSERT_IMP(a_end_is_nul, rsp_valid && rsp_string_end, rsp_out_char == 7'h00, "end not zero")
   `UTA_ASSERT_IMP(a_hold_input, rsp_valid && !rsp_run_last, !req_ready, "item taken mid run")
   `UTA_ASSERT_NEXT(a_term_follows,
                    accept && req_in_byte == 8'h00 && cfg.capacity != '0,
                    rsp_valid, "no result after zero byte")

endmodule

`default_nettype wire
